### hw/rtl/axis_angle_to_homogeneous_transform_top_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef AXIS_ANGLE_TO_HOMOGENEOUS_TRANSFORM_TOP_ASSERT_SVH
`define AXIS_ANGLE_TO_HOMOGENEOUS_TRANSFORM_TOP_ASSERT_SVH
// Property that must hold in the cycle after the antecedent.
`define AA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
// Property that must hold in the same cycle as the antecedent.
`define AA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`endif

### hw/rtl/aahtf_pkg.sv
// ----------------------------------------------------------------------------
// aahtf_pkg
// Types and constants of the axis-angle to homogeneous transform block.
// ----------------------------------------------------------------------------
package aahtf_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int TRIG_FRAC    = 30;
    localparam int OUT_FRAC     = 14;
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] axis_azimuth;
        logic signed [15:0] axis_elevation;
        logic signed [15:0] turn_angle;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
        logic signed [31:0] col3_x;
        logic signed [31:0] col3_y;
        logic signed [31:0] col3_z;
    } t_out_item;

    // Arctangent of 2^-i as a fraction of a full turn scaled to 2^32.
    function automatic logic signed [33:0] arc_at(input int idx);
        logic signed [33:0] t;
        begin
            case (idx)
                0: t = 34'sd536870912;   1: t = 34'sd316933406;
                2: t = 34'sd167458907;   3: t = 34'sd85004756;
                4: t = 34'sd42667331;    5: t = 34'sd21354465;
                6: t = 34'sd10679838;    7: t = 34'sd5340245;
                8: t = 34'sd2670163;     9: t = 34'sd1335087;
                10: t = 34'sd667544;     11: t = 34'sd333772;
                12: t = 34'sd166886;     13: t = 34'sd83443;
                14: t = 34'sd41722;      15: t = 34'sd20861;
                16: t = 34'sd10430;      17: t = 34'sd5215;
                18: t = 34'sd2608;       19: t = 34'sd1304;
                20: t = 34'sd652;        21: t = 34'sd326;
                22: t = 34'sd163;        23: t = 34'sd81;
                24: t = 34'sd41;         25: t = 34'sd20;
                26: t = 34'sd10;         27: t = 34'sd5;
                28: t = 34'sd3;          29: t = 34'sd1;
                default: t = 34'sd0;
            endcase
            return t;
        end
    endfunction

endpackage

### hw/rtl/aahtf_cordic.sv
// ----------------------------------------------------------------------------
// aahtf_cordic
// Pipelined sine and cosine: quadrant fold, one CORDIC rotation per stage,
// then rounding to the coefficient format with a clamp to plus or minus one.
// ----------------------------------------------------------------------------
module aahtf_cordic #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ANGLE_BITS-1:0]       i_angle,
    output logic signed [COEF_FRAC_BITS+1:0] o_sin,
    output logic signed [COEF_FRAC_BITS+1:0] o_cos
);
    import aahtf_pkg::*;

    localparam int N  = CORDIC_STEPS;
    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int RS = TRIG_FRAC - COEF_FRAC_BITS;

    logic signed [33:0] r_x [N+1];
    logic signed [33:0] r_y [N+1];
    logic signed [33:0] r_z [N+1];
    logic [1:0]         r_q [N+1];
    logic signed [CW-1:0] r_sin, r_cos;

    logic [31:0] phase;
    logic [31:0] resid;
    logic [1:0]  quad;

    always_comb begin
        phase = {i_angle, {(32 - ANGLE_BITS){1'b0}}};
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'd0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0] <= CORDIC_X0;
            r_y[0] <= '0;
            r_z[0] <= 34'(signed'(resid));
            r_q[0] <= quad;
        end
    end

    for (genvar g = 0; g < N; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_z[g][33]) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - arc_at(g);
                end else begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + arc_at(g);
                end
                r_q[g+1] <= r_q[g];
            end
        end
    end

    function automatic logic signed [CW-1:0] fin(input logic signed [33:0] v);
        logic signed [34:0] t;
        logic signed [34:0] one;
        begin
            one = 35'sd1 <<< COEF_FRAC_BITS;
            t = (35'(v) + (35'sd1 <<< (RS - 1))) >>> RS;
            if (t > one) t = one;
            if (t < -one) t = -one;
            return CW'(t);
        end
    endfunction

    logic signed [33:0] xc, yc, cs, sn;
    always_comb begin
        xc = r_x[N];
        yc = r_y[N];
        case (r_q[N])
            2'd0: begin cs = xc;  sn = yc;  end
            2'd1: begin cs = -yc; sn = xc;  end
            2'd2: begin cs = -xc; sn = -yc; end
            default: begin cs = yc; sn = -xc; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cos <= fin(cs);
            r_sin <= fin(sn);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;
endmodule

### hw/rtl/aahtf_matrix.sv
// ----------------------------------------------------------------------------
// aahtf_matrix
// Pipelined Rodrigues products: axis, outer products and cross terms, scaling
// by one minus cosine, sum and conversion to saturated Q1.14.
// ----------------------------------------------------------------------------
module aahtf_matrix #(
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic i_clk,
    input  logic i_en,
    input  logic signed [COEF_FRAC_BITS+1:0] i_sa,
    input  logic signed [COEF_FRAC_BITS+1:0] i_ca,
    input  logic signed [COEF_FRAC_BITS+1:0] i_se,
    input  logic signed [COEF_FRAC_BITS+1:0] i_ce,
    input  logic signed [COEF_FRAC_BITS+1:0] i_s,
    input  logic signed [COEF_FRAC_BITS+1:0] i_c,
    output logic signed [15:0] o_m [9]
);
    import aahtf_pkg::*;

    localparam int F  = COEF_FRAC_BITS;
    localparam int W  = F + 4;   // holds products of values up to about 2
    localparam int PW = 2 * W;

    function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [PW-1:0] p;
        begin
            p = PW'(a) * PW'(b);
            p = (p + (PW'(1) <<< (F - 1))) >>> F;
            return W'(p);
        end
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [W-1:0] v);
        logic signed [W+OUT_FRAC:0] t;
        logic signed [W+OUT_FRAC:0] one;
        begin
            one = (W + OUT_FRAC + 1)'(1) <<< OUT_FRAC;
            if (F >= OUT_FRAC) begin
                if (F == OUT_FRAC) t = (W + OUT_FRAC + 1)'(v);
                else t = ((W + OUT_FRAC + 1)'(v)
                          + ((W + OUT_FRAC + 1)'(1) <<< ((F > OUT_FRAC) ? F - OUT_FRAC - 1 : 0)))
                         >>> (F - OUT_FRAC);
            end else begin
                t = (W + OUT_FRAC + 1)'(v) <<< (OUT_FRAC - F);
            end
            if (t > one) t = one;
            if (t < -one) t = -one;
            return 16'(t);
        end
    endfunction

    // Stage A: axis and one minus cosine.
    logic signed [W-1:0] r_kx, r_ky, r_kz, r_v;
    logic signed [W-1:0] r_s1, r_c1;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kx <= qmul(W'(i_ca), W'(i_ce));
            r_ky <= qmul(W'(i_sa), W'(i_ce));
            r_kz <= W'(i_se);
            r_v  <= (W'(1) <<< F) - W'(i_c);
            r_s1 <= W'(i_s);
            r_c1 <= W'(i_c);
        end
    end

    // Stage B: outer products and cross terms.
    logic signed [W-1:0] r_xx, r_yy, r_zz, r_xy, r_zx, r_yz;
    logic signed [W-1:0] r_sx, r_sy, r_sz, r_v2, r_c2;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xx <= qmul(r_kx, r_kx);
            r_yy <= qmul(r_ky, r_ky);
            r_zz <= qmul(r_kz, r_kz);
            r_xy <= qmul(r_kx, r_ky);
            r_zx <= qmul(r_kz, r_kx);
            r_yz <= qmul(r_ky, r_kz);
            r_sx <= qmul(r_kx, r_s1);
            r_sy <= qmul(r_ky, r_s1);
            r_sz <= qmul(r_kz, r_s1);
            r_v2 <= r_v;
            r_c2 <= r_c1;
        end
    end

    // Stage C: scale by one minus cosine.
    logic signed [W-1:0] r_axx, r_ayy, r_azz, r_axy, r_azx, r_ayz;
    logic signed [W-1:0] r_sx3, r_sy3, r_sz3, r_c3;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axx <= qmul(r_xx, r_v2);
            r_ayy <= qmul(r_yy, r_v2);
            r_azz <= qmul(r_zz, r_v2);
            r_axy <= qmul(r_xy, r_v2);
            r_azx <= qmul(r_zx, r_v2);
            r_ayz <= qmul(r_yz, r_v2);
            r_sx3 <= r_sx;
            r_sy3 <= r_sy;
            r_sz3 <= r_sz;
            r_c3  <= r_c2;
        end
    end

    // Stage D: sums and output conversion.
    logic signed [15:0] r_m [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m[0] <= to_out(r_axx + r_c3);
            r_m[1] <= to_out(r_axy - r_sz3);
            r_m[2] <= to_out(r_azx + r_sy3);
            r_m[3] <= to_out(r_axy + r_sz3);
            r_m[4] <= to_out(r_ayy + r_c3);
            r_m[5] <= to_out(r_ayz - r_sx3);
            r_m[6] <= to_out(r_azx - r_sy3);
            r_m[7] <= to_out(r_ayz + r_sx3);
            r_m[8] <= to_out(r_azz + r_c3);
        end
    end

    assign o_m = r_m;
endmodule

### hw/rtl/axis_angle_to_homogeneous_transform_top.sv
// Pipeline: the sine and cosine stages are followed by 4 matrix stages.
// Throughput: one transaction per cycle; the whole pipeline advances when the
// output register is empty or being read, and holds otherwise.
// Reset: synchronous active-low reset clears all stage valid bits; data
// registers are not reset.
// ----------------------------------------------------------------------------
// axis_angle_to_homogeneous_transform_top
// Axis-angle plus translation to homogeneous transform, fully pipelined.
// ----------------------------------------------------------------------------
module axis_angle_to_homogeneous_transform_top #(
    parameter int ANGLE_BITS     = 16,
    parameter int COEF_FRAC_BITS = 14
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  aahtf_pkg::t_in_item  i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output aahtf_pkg::t_out_item o_data
);
    import aahtf_pkg::*;

    localparam int CW    = COEF_FRAC_BITS + 2;
    localparam int DEPTH = CORDIC_STEPS + 2 + 4;

    logic en;
    logic [DEPTH-1:0] r_vld;
    logic [31:0] r_tx [DEPTH];
    logic [31:0] r_ty [DEPTH];
    logic [31:0] r_tz [DEPTH];
    logic signed [CW-1:0] sa, ca, se, ce, sn, cs;
    logic signed [15:0] m [9];

    // Whole pipeline moves together; a full last stage waits for the sink.
    assign en      = !r_vld[DEPTH-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tx[0] <= i_data.shift_x;
            r_ty[0] <= i_data.shift_y;
            r_tz[0] <= i_data.shift_z;
            for (int k = 1; k < DEPTH; k++) begin
                r_tx[k] <= r_tx[k-1];
                r_ty[k] <= r_ty[k-1];
                r_tz[k] <= r_tz[k-1];
            end
        end
    end

    aahtf_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_az (
        .i_clk(i_clk), .i_en(en),
        .i_angle(ANGLE_BITS'(i_data.axis_azimuth)), .o_sin(sa), .o_cos(ca));
    aahtf_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_el (
        .i_clk(i_clk), .i_en(en),
        .i_angle(ANGLE_BITS'(i_data.axis_elevation)), .o_sin(se), .o_cos(ce));
    aahtf_cordic #(.ANGLE_BITS(ANGLE_BITS), .COEF_FRAC_BITS(COEF_FRAC_BITS)) u_turn (
        .i_clk(i_clk), .i_en(en),
        .i_angle(ANGLE_BITS'(i_data.turn_angle)), .o_sin(sn), .o_cos(cs));

    aahtf_matrix #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_mat (
        .i_clk(i_clk), .i_en(en),
        .i_sa(sa), .i_ca(ca), .i_se(se), .i_ce(ce), .i_s(sn), .i_c(cs),
        .o_m(m));

    always_comb begin
        o_data.m00 = m[0]; o_data.m01 = m[1]; o_data.m02 = m[2];
        o_data.m10 = m[3]; o_data.m11 = m[4]; o_data.m12 = m[5];
        o_data.m20 = m[6]; o_data.m21 = m[7]; o_data.m22 = m[8];
        o_data.col3_x = r_tx[DEPTH-1];
        o_data.col3_y = r_ty[DEPTH-1];
        o_data.col3_z = r_tz[DEPTH-1];
    end
endmodule

### hw/rtl/aahtf_checker.sv
// ----------------------------------------------------------------------------
// aahtf_checker
// Port-level checks of the transform block, bound to its top level.
// ----------------------------------------------------------------------------
`include "axis_angle_to_homogeneous_transform_top_assert.svh"
module aahtf_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_ready,
    input logic                 o_valid,
    input logic                 i_ready,
    input aahtf_pkg::t_out_item o_data
);
    // A stalled result transaction keeps its payload.
    `AA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_data), "hold")
    // The input side may only stall while a result waits on the sink.
    `AA_ASSERT_NOW(a_ready_stall, i_clk, i_rst_n, !o_ready, o_valid && !i_ready, "bad stall")
    // The m00 and m22 entries never exceed plus or minus one.
    `AA_ASSERT_NOW(a_range, i_clk, i_rst_n, o_valid,
        $signed(o_data.m00) <= 16384 && $signed(o_data.m00) >= -16384 &&
        $signed(o_data.m22) <= 16384 && $signed(o_data.m22) >= -16384, "range")
    // A result cannot appear in the cycle after reset is sampled low.
    `AA_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n, !o_valid, "valid after reset")
endmodule

bind axis_angle_to_homogeneous_transform_top aahtf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));

### sim/axis_angle_to_homogeneous_transform_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle to homogeneous transform testbench
// Drives pose items into the pipeline, computes each expected transform with
// a CORDIC/Rodrigues model of its own, and compares every output transaction.
// ----------------------------------------------------------------------------
module axis_angle_to_homogeneous_transform_top_tb;
    import aahtf_pkg::*;

    localparam int ANG_BITS  = 16;
    localparam int FRAC_BITS = 14;
    localparam int OUT_ONE   = 16384;
    localparam int PIPE_LAT  = 36;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    t_out_item pending_poses[$];
    int        error_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_off_cycles;

    axis_angle_to_homogeneous_transform_top #(
        .ANGLE_BITS    (ANG_BITS),
        .COEF_FRAC_BITS(FRAC_BITS)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_data (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_sh(longint v, int s);
        if (s == 0) return v;
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clamp_unit(longint v);
        longint one;
        one = longint'(1) << FRAC_BITS;
        if (v > one) return one;
        if (v < -one) return -one;
        return v;
    endfunction

    function automatic longint fx_mul(longint a, longint b);
        return round_sh(a * b, FRAC_BITS);
    endfunction

    // Quadrant fold followed by 30 CORDIC rotations in Q30.
    function automatic void trig_of(input logic [15:0] ang, output longint sn,
                                    output longint cs);
        logic [31:0] phase;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x, y, z, dx, dy, c, s;
        phase = 32'(ang[ANG_BITS-1:0]) << (32 - ANG_BITS);
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - (32'(quad) << 30);
        z = longint'($signed(resid));
        x = longint'(CORDIC_X0);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= longint'(arc_at(i));
            end else begin
                x += dx; y -= dy; z += longint'(arc_at(i));
            end
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        cs = clamp_unit(round_sh(c, TRIG_FRAC - FRAC_BITS));
        sn = clamp_unit(round_sh(s, TRIG_FRAC - FRAC_BITS));
    endfunction

    function automatic logic [15:0] to_q14(longint v);
        if (FRAC_BITS >= OUT_FRAC) v = round_sh(v, FRAC_BITS - OUT_FRAC);
        else v = v * (longint'(1) << (OUT_FRAC - FRAC_BITS));
        if (v > OUT_ONE) v = OUT_ONE;
        if (v < -OUT_ONE) v = -OUT_ONE;
        return v[15:0];
    endfunction

    function automatic t_out_item pose_matrix(t_in_item p);
        t_out_item r;
        longint    sa, ca, se, ce, s, c, v, kx, ky, kz;
        trig_of(p.axis_azimuth, sa, ca);
        trig_of(p.axis_elevation, se, ce);
        trig_of(p.turn_angle, s, c);
        kx = fx_mul(ca, ce);
        ky = fx_mul(sa, ce);
        kz = se;
        v  = (longint'(1) << FRAC_BITS) - c;
        r.m00 = to_q14(fx_mul(fx_mul(kx, kx), v) + c);
        r.m01 = to_q14(fx_mul(fx_mul(kx, ky), v) - fx_mul(kz, s));
        r.m02 = to_q14(fx_mul(fx_mul(kz, kx), v) + fx_mul(ky, s));
        r.m10 = to_q14(fx_mul(fx_mul(kx, ky), v) + fx_mul(kz, s));
        r.m11 = to_q14(fx_mul(fx_mul(ky, ky), v) + c);
        r.m12 = to_q14(fx_mul(fx_mul(ky, kz), v) - fx_mul(kx, s));
        r.m20 = to_q14(fx_mul(fx_mul(kz, kx), v) - fx_mul(ky, s));
        r.m21 = to_q14(fx_mul(fx_mul(ky, kz), v) + fx_mul(kx, s));
        r.m22 = to_q14(fx_mul(fx_mul(kz, kz), v) + c);
        r.col3_x = p.shift_x;
        r.col3_y = p.shift_y;
        r.col3_z = p.shift_z;
        return r;
    endfunction

    // Valid stays high between back-to-back transactions; it drops only
    // while the sender idles or after the last item.
    task automatic send_pose(input t_in_item p);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= p;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_poses.push_back(pose_matrix(p));
        @(negedge i_clk);
    endtask

    task automatic send_angles(input int az, input int el, input int tn);
        t_in_item p;
        p.axis_azimuth   = 16'(az);
        p.axis_elevation = 16'(el);
        p.turn_angle     = 16'(tn);
        p.shift_x        = $urandom;
        p.shift_y        = $urandom;
        p.shift_z        = $urandom;
        send_pose(p);
    endtask

    function automatic logic [15:0] pick_angle();
        case ($urandom_range(3))
            0: return 16'($urandom_range(7) * 16'h2000);
            1: return 16'($urandom_range(7) * 16'h2000 + $urandom_range(8) - 4);
            default: return 16'($urandom);
        endcase
    endfunction

    // Receiver: random idling plus one long hold-off when requested.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_poses.size() == 0) begin
                error_count++;
                $display("%0t: unexpected transaction, actual %h", $time, o_data);
            end else begin
                want = pending_poses.pop_front();
                if (want !== o_data) begin
                    error_count++;
                    $display("%0t: mismatch, expected %h actual %h", $time, want, o_data);
                end
            end
        end
    end

    task automatic test_directed();
        send_angles(0, 0, 0);
        send_angles(0, 0, 16'h8000);
        send_angles(0, 0, 16'h7FFF);
        send_angles(16'h8000, 16'h8000, 16'h4000);
        send_angles(16'h7FFF, 16'h7FFF, 16'hC000);
        send_angles(16'h4000, 0, 16'h4000);
        send_angles(0, 16'h4000, 16'h2000);
        send_angles(16'hC000, 16'hC000, 16'hE000);
        send_angles(16'h2000, 16'h2000, 16'h1555);
        send_angles(16'hFFFF, 16'h0001, 16'h8001);
        begin
            t_in_item p;
            p = '1;
            send_pose(p);
            p = '0;
            p.shift_x = 32'h8000_0000; p.shift_y = 32'h7FFF_FFFF; p.shift_z = 32'h5555_AAAA;
            send_pose(p);
        end
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) send_angles(pick_angle(), pick_angle(), pick_angle());
    endtask

    task automatic test_back_pressure();
        hold_off_cycles = 200;
        test_random(60);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data  = '0;
        error_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_back_pressure();
        send_idle_pct = 25; recv_idle_pct = 57;
        test_random(530);
        send_idle_pct = 57; recv_idle_pct = 25;
        test_random(530);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(530);
        i_valid <= 1'b0;
        while (pending_poses.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
        if (error_count == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
